>>> hdl/pwmps_pkg.sv
// Shared widths, constants and the divider cell state for the PWM prescaler selector.
`default_nettype none

package pwmps_pkg;

  localparam int CLOCK_W    = 28;
  localparam int HZ_W       = 27;
  localparam int CODE_W     = 3;
  localparam int PERIOD_W   = 16;
  localparam int DIV_STEPS  = CLOCK_W;
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd100000000;

  // Register word index of clock_hz
  localparam logic [ADDR_W-3:0] REG_CLOCK_HZ = 1'b0;

  // Partial remainder, dividend/quotient shift word and divisor of one division
  typedef struct packed {
    logic [CLOCK_W-1:0] rem;
    logic [CLOCK_W-1:0] num;
    logic [HZ_W-1:0]    den;
  } div_state_t;

endpackage

`default_nettype wire

>>> hdl/pwmps_div_cell.sv
// One restoring-division cell: produces one quotient bit and hands the state on.
`default_nettype none

module pwmps_div_cell
  import pwmps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       move,
  input  logic       in_valid,
  input  div_state_t in_state,
  output logic       valid,
  output div_state_t state
);

  logic [CLOCK_W:0]   shifted;
  logic [CLOCK_W:0]   diff;
  logic               ge;
  div_state_t         state_next;

  always_comb begin
    shifted = {in_state.rem, in_state.num[CLOCK_W-1]};
    ge      = shifted >= {2'b00, in_state.den};
    diff    = shifted - {2'b00, in_state.den};
    state_next.rem = ge ? diff[CLOCK_W-1:0] : shifted[CLOCK_W-1:0];
    state_next.num = {in_state.num[CLOCK_W-2:0], ge};
    state_next.den = in_state.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (move) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pwmps_period.sv
// Prescaler pair selection from the quotient, period scaling and the result register.
`default_nettype none

module pwmps_period
  import pwmps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CLOCK_W-1:0]  quot,
  input  logic                rem_nonzero,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                ok,
  output logic [CODE_W-1:0]   coarse_code,
  output logic [CODE_W-1:0]   fine_code,
  output logic [PERIOD_W-1:0] period_count
);

  localparam int PAIR_COUNT  = 64;
  localparam int PAIR_W      = 6;
  localparam int MAX_PRODUCT = 1792;
  localparam int TB_MAX      = 65535;
  localparam int SHIFT_W     = 4;
  localparam int ODD_W       = 2;
  localparam int X_W         = 19;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 27;

  localparam logic [CLOCK_W-1:0] TOO_LOW_LIMIT = CLOCK_W'(MAX_PRODUCT * TB_MAX);

  localparam logic [ODD_W-1:0] ODD_1 = 2'd0;
  localparam logic [ODD_W-1:0] ODD_3 = 2'd1;
  localparam logic [ODD_W-1:0] ODD_5 = 2'd2;
  localparam logic [ODD_W-1:0] ODD_7 = 2'd3;

  function automatic int pair_product(input int i);
    int c;
    int f;
    c = i >> 3;
    f = i & 7;
    return (1 << c) * ((f == 0) ? 1 : 2 * f);
  endfunction

  function automatic logic [PAIR_COUNT-1:0] lower_mask(input int i);
    logic [PAIR_COUNT-1:0] m;
    m = '0;
    for (int j = 0; j < PAIR_COUNT; j++) begin
      m[j] = pair_product(j) < pair_product(i);
    end
    return m;
  endfunction

  function automatic logic [PAIR_COUNT-1:0] same_before_mask(input int i);
    logic [PAIR_COUNT-1:0] m;
    m = '0;
    for (int j = 0; j < PAIR_COUNT; j++) begin
      m[j] = (j < i) && (pair_product(j) == pair_product(i));
    end
    return m;
  endfunction

  // Power-of-two part of the fine divisor
  function automatic logic [SHIFT_W-1:0] fine_shift(input logic [CODE_W-1:0] f);
    logic [SHIFT_W-1:0] s;
    case (f)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd1;
      3'd2:    s = 4'd2;
      3'd3:    s = 4'd1;
      3'd4:    s = 4'd3;
      3'd5:    s = 4'd1;
      3'd6:    s = 4'd2;
      3'd7:    s = 4'd1;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Odd part of the fine divisor
  function automatic logic [ODD_W-1:0] fine_odd(input logic [CODE_W-1:0] f);
    logic [ODD_W-1:0] o;
    case (f)
      3'd3:    o = ODD_3;
      3'd5:    o = ODD_5;
      3'd6:    o = ODD_3;
      3'd7:    o = ODD_7;
      default: o = ODD_1;
    endcase
    return o;
  endfunction

  // Rounded-up reciprocal scaled by two to the RECIP_SHIFT
  function automatic logic [RECIP_W-1:0] recip(input logic [ODD_W-1:0] o);
    logic [RECIP_W-1:0] r;
    case (o)
      ODD_1:   r = 28'd134217728;
      ODD_3:   r = 28'd44739243;
      ODD_5:   r = 28'd26843546;
      ODD_7:   r = 28'd19173962;
      default: r = 28'd134217728;
    endcase
    return r;
  endfunction

  logic rdy1, rdy2, rdy3;
  logic v1, v2, v3;

  assign rdy3     = !v3 || !res_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1: threshold compares against every pair
  logic [PAIR_COUNT-1:0] cand_c;
  logic                  too_low_c;
  logic [PAIR_COUNT-1:0] cand1;
  logic                  too_low1;
  logic [CLOCK_W-1:0]    quot1;

  assign too_low_c = (quot > TOO_LOW_LIMIT) || ((quot == TOO_LOW_LIMIT) && rem_nonzero);

  // Stage 2: smallest fitting product, first in scan order on a tie
  logic [PAIR_COUNT-1:0] win;

  for (genvar i = 0; i < PAIR_COUNT; i++) begin : g_pair
    localparam logic [CLOCK_W-1:0]    LIMIT       = CLOCK_W'(pair_product(i) * TB_MAX);
    localparam bit                    ELIGIBLE    = pair_product(i) < MAX_PRODUCT;
    localparam logic [PAIR_COUNT-1:0] LOWER       = lower_mask(i);
    localparam logic [PAIR_COUNT-1:0] SAME_BEFORE = same_before_mask(i);

    assign cand_c[i] = ELIGIBLE && (LIMIT > quot);
    assign win[i]    = cand1[i] && !(|(cand1 & LOWER)) && !(|(cand1 & SAME_BEFORE));
  end

  logic [PAIR_W-1:0]  pick;
  logic [CODE_W-1:0]  coarse_c, fine_c;
  logic [SHIFT_W-1:0] shift_c;
  logic [CLOCK_W-1:0] scaled;

  always_comb begin
    pick = '0;
    for (int i = 0; i < PAIR_COUNT; i++) begin
      if (win[i]) begin
        pick = pick | PAIR_W'(i);
      end
    end
    // keep the default pair when nothing fits
    if (!(|win)) begin
      pick = PAIR_W'(PAIR_COUNT - 1);
    end
    coarse_c = pick[PAIR_W-1:CODE_W];
    fine_c   = pick[CODE_W-1:0];
    shift_c  = {1'b0, coarse_c} + fine_shift(fine_c);
    scaled   = quot1 >> shift_c;
  end

  logic               ok2;
  logic [CODE_W-1:0]  coarse2, fine2;
  logic [X_W-1:0]     x2;
  logic [ODD_W-1:0]   odd2;

  // Stage 3: divide by the odd factor through its reciprocal
  logic [X_W+RECIP_W-1:0] prod;

  assign prod = x2 * recip(odd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cand1    <= cand_c;
      too_low1 <= too_low_c;
      quot1    <= quot;
    end
    if (rdy2) begin
      ok2     <= !too_low1;
      coarse2 <= coarse_c;
      fine2   <= fine_c;
      x2      <= scaled[X_W-1:0];
      odd2    <= fine_odd(fine_c);
    end
    if (rdy3) begin
      ok           <= ok2;
      coarse_code  <= ok2 ? coarse2 : '0;
      fine_code    <= ok2 ? fine2 : '0;
      period_count <= ok2 ? prod[RECIP_SHIFT +: PERIOD_W] : '0;
    end
  end

  assign res_valid = v3;

  a_win_onehot: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $onehot0(win))
    else $error("more than one prescaler pair selected");

  a_low_no_cand: assert property (@(posedge clk) disable iff (rst)
    (v1 && too_low1) |-> (cand1 == '0))
    else $error("fitting pair found for a frequency flagged too low");

  a_scaled_fits: assert property (@(posedge clk) disable iff (rst)
    (v1 && !too_low1) |-> (scaled[CLOCK_W-1:X_W] == '0))
    else $error("scaled quotient exceeds reciprocal range");

endmodule

`default_nettype wire

>>> hdl/pwm_prescaler_period_select_core.sv
// Top level: configuration register, chain of division cells and the selection stages.
//
// Usage: write clock_hz (time-base clock in hertz) over the APB port at byte address 0
// while the block is idle; it resets to 100 MHz. Each request on the req channel carries
// target_hz and yields exactly one result on the res channel: ok, coarse_code, fine_code
// and period_count. A frequency too low for the largest prescaler gives ok low and all
// other fields zero.
// Pipeline: a transferred request passes through 28 cells of a restoring divider (one
// quotient bit of clock_hz / target_hz per cell, the first cell loading at the transfer
// edge), then the compare stage, the pair select stage and the reciprocal multiply into
// the result register. Throughput: one request per cycle while nothing stalls, set by
// the cell chain, which can take a new division every cycle while it can advance.
// Stalls: each stage advances when it or any stage after it is empty, so bubbles close
// up while res_stall is high; req_stall rises only once every stage holds an item.
// Reset: synchronous, clears all valid flags and reloads clock_hz; in-flight items drop.
`default_nettype none

module pwm_prescaler_period_select_core
  import pwmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [HZ_W-1:0]       target_hz,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  ok,
  output logic [CODE_W-1:0]     coarse_code,
  output logic [CODE_W-1:0]     fine_code,
  output logic [PERIOD_W-1:0]   period_count
);

  logic [CLOCK_W-1:0] clock_hz;
  logic               reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1:2] == REG_CLOCK_HZ;
  assign prdata  = reg_hit ? APB_DATA_W'(clock_hz) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      clock_hz <= pwdata[CLOCK_W-1:0];
    end
  end

  div_state_t             cell_in  [DIV_STEPS];
  div_state_t             cell_out [DIV_STEPS];
  logic [DIV_STEPS-1:0]   cell_in_valid;
  logic [DIV_STEPS-1:0]   cell_valid;
  logic [DIV_STEPS:0]     ready;
  logic                   sel_ready;

  assign cell_in[0]       = '{rem: '0, num: clock_hz, den: target_hz};
  assign cell_in_valid[0] = req_valid;
  assign ready[DIV_STEPS] = sel_ready;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign cell_in[k]       = cell_out[k-1];
      assign cell_in_valid[k] = cell_valid[k-1];
    end

    // advance when this or any later cell has a gap or the selector is ready to take a transfer
    assign ready[k] = sel_ready || !(&cell_valid[DIV_STEPS-1:k]);

    pwmps_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .move     (ready[k]),
      .in_valid (cell_in_valid[k]),
      .in_state (cell_in[k]),
      .valid    (cell_valid[k]),
      .state    (cell_out[k])
    );
  end

  assign req_stall = !ready[0];

  pwmps_period u_period (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cell_valid[DIV_STEPS-1]),
    .in_ready     (sel_ready),
    .quot         (cell_out[DIV_STEPS-1].num),
    .rem_nonzero  (|cell_out[DIV_STEPS-1].rem),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .ok           (ok),
    .coarse_code  (coarse_code),
    .fine_code    (fine_code),
    .period_count (period_count)
  );

endmodule

`default_nettype wire

>>> verif/tb_pwm_prescaler_period_select_core.sv
// Self-checking testbench for the PWM prescaler and period selection core.
module tb_pwm_prescaler_period_select_core;
  import pwmps_pkg::*;

  localparam longint unsigned MAX_PRODUCT = 64'd1792;
  localparam longint unsigned TB_TOP      = 64'd65535;
  localparam int              IDLE_LIMIT  = 5000;
  localparam int              DRAIN_WAIT  = 40;
  localparam int              HOLD_OFF    = 250;

  localparam logic [ADDR_W-1:0] CLOCK_HZ_ADDR = {REG_CLOCK_HZ, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR    = {~REG_CLOCK_HZ, 2'b00};
  localparam logic [HZ_W-1:0]   HZ_MAX        = {HZ_W{1'b1}};

  typedef struct packed {
    logic                ok;
    logic [CODE_W-1:0]   coarse;
    logic [CODE_W-1:0]   fine;
    logic [PERIOD_W-1:0] period;
  } pwm_setting_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  req_valid;
  logic                  req_stall;
  logic [HZ_W-1:0]       target_hz;
  logic                  res_valid;
  logic                  res_stall;
  logic                  ok;
  logic [CODE_W-1:0]     coarse_code;
  logic [CODE_W-1:0]     fine_code;
  logic [PERIOD_W-1:0]   period_count;

  pwm_setting_t       pending_settings[$];
  logic [CLOCK_W-1:0] clock_hz_shadow;
  int                 mismatch_count;
  int                 hold_cycles;
  bit                 steady;

  pwm_prescaler_period_select_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .target_hz    (target_hz),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .ok           (ok),
    .coarse_code  (coarse_code),
    .fine_code    (fine_code),
    .period_count (period_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned divide_product(input int c, input int f);
    return (64'd1 << c) * ((f == 0) ? 64'd1 : 64'(2 * f));
  endfunction

  // Smallest coarse*fine product that keeps the period inside 16 bits
  function automatic pwm_setting_t select_prescaler(input logic [CLOCK_W-1:0] clock_hz,
                                                    input logic [HZ_W-1:0] hz);
    longint unsigned hz64;
    longint unsigned clk64;
    longint unsigned best_p;
    longint unsigned p;
    int              best_c;
    int              best_f;
    pwm_setting_t    s;
    s      = '0;
    hz64   = hz;
    clk64  = clock_hz;
    if (hz64 == 0 || clk64 > MAX_PRODUCT * TB_TOP * hz64) return s;
    best_c = 7;
    best_f = 7;
    best_p = divide_product(best_c, best_f);
    for (int c = 0; c < 8; c++) begin
      for (int f = 0; f < 8; f++) begin
        p = divide_product(c, f);
        if (p < best_p && p * hz64 * TB_TOP > clk64) begin
          best_c = c;
          best_f = f;
          best_p = p;
        end
      end
    end
    s.ok     = 1'b1;
    s.coarse = best_c[CODE_W-1:0];
    s.fine   = best_f[CODE_W-1:0];
    s.period = PERIOD_W'(clk64 / (best_p * hz64));
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mix of small, mid, full-range and near-threshold frequencies
  function automatic logic [HZ_W-1:0] pick_target();
    longint unsigned base;
    longint signed   hz;
    case ($urandom_range(0, 3))
      0: hz = $urandom_range(1, 2000);
      1: hz = $urandom_range(1, 65535);
      2: hz = $urandom & HZ_MAX;
      default: begin
        base = 64'(clock_hz_shadow) /
               (TB_TOP * divide_product($urandom_range(0, 7), $urandom_range(0, 7)));
        hz = longint'(base) + $urandom_range(0, 2) - 1;
      end
    endcase
    if (hz < 1) hz = 1;
    if (hz > longint'(HZ_MAX)) hz = HZ_MAX;
    return hz[HZ_W-1:0];
  endfunction

  task automatic write_register(input logic [ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[ADDR_W-1:2] == REG_CLOCK_HZ) clock_hz_shadow = data[CLOCK_W-1:0];
  endtask

  task automatic send_request(input logic [HZ_W-1:0] hz);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    target_hz <= hz;
    do @(posedge clk); while (req_stall);
    pending_settings.push_back(select_prescaler(clock_hz_shadow, hz));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_clock(input logic [APB_DATA_W-1:0] data);
    drain();
    write_register(CLOCK_HZ_ADDR, data);
  endtask

  task automatic test_directed();
    send_request(27'd1);
    send_request(27'd2);
    send_request(27'd0);
    send_request(27'd1526);
    send_request(27'd1525);
    send_request(27'd100000000);
    send_request(HZ_MAX);
    send_request(27'h5555555);
    send_request(27'h2AAAAAA);
    // exact boundary keeps the largest divider pair
    set_clock(32'd117438720);
    send_request(27'd1);
    send_request(27'd2);
    set_clock(32'd234877440);
    send_request(27'd2);
    send_request(27'd1);
    set_clock(32'd0);
    send_request(27'd5);
    send_request(HZ_MAX);
    set_clock(32'd1000000);
    send_request(27'd100000000);
    send_request(27'd15);
    set_clock(32'h0FFFFFFF);
    send_request(27'd1);
    send_request(27'd3);
    // spare index must leave the clock untouched
    drain();
    write_register(SPARE_ADDR, 32'h01234567);
    send_request(27'd1000);
    // upper data bits beyond the register width are dropped
    set_clock(32'hF5F5E100);
    send_request(27'd1000);
    drain();
  endtask

  task automatic test_random_sweep();
    logic [APB_DATA_W-1:0] clocks[5];
    clocks[0] = 32'd1000000;
    clocks[1] = 32'd200000000;
    clocks[2] = $urandom_range(1000000, 200000000);
    clocks[3] = 32'd100000000;
    clocks[4] = $urandom_range(1000000, 200000000);
    foreach (clocks[i]) begin
      set_clock(clocks[i]);
      steady = (i == 3);
      repeat (80) send_request(pick_target());
    end
    drain();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    steady      = 1'b1;
    hold_cycles = HOLD_OFF;
    repeat (60) send_request(pick_target());
    drain();
    steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_request(pick_target());
    drain();
    repeat (20) send_request(pick_target());
    drain();
  endtask

  // Result side: random stall, with a long hold-off on request
  initial begin
    int n;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        res_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (steady || n == 0) begin
          res_stall <= 1'b0;
        end else begin
          res_stall <= 1'b1;
          repeat (n) @(posedge clk);
          res_stall <= 1'b0;
        end
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  initial begin
    pwm_setting_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (pending_settings.size() == 0) begin
          $error("unexpected result transfer");
          mismatch_count++;
        end else begin
          want = pending_settings.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            mismatch_count++;
          end
          if (coarse_code !== want.coarse) begin
            $error("coarse_code: expected %0d, got %0d", want.coarse, coarse_code);
            mismatch_count++;
          end
          if (fine_code !== want.fine) begin
            $error("fine_code: expected %0d, got %0d", want.fine, fine_code);
            mismatch_count++;
          end
          if (period_count !== want.period) begin
            $error("period_count: expected %0d, got %0d", want.period, period_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle = 0;
      else idle++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    hold_cycles     = 0;
    steady          = 1'b0;
    clock_hz_shadow = CLOCK_RESET;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    req_valid <= 1'b0;
    target_hz <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_sweep();
    test_backpressure();
    test_sender_pause();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_settings.size() != 0) begin
      $error("%0d results never arrived", pending_settings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
